// File: sv/frga_pkg.sv
package frga_pkg;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ASCII = 2'd1,
    KIND_HANZI = 2'd2
  } font_kind_t;

  typedef struct packed {
    logic [23:0] base;
    logic [5:0]  width;
    logic [5:0]  height;
    logic [7:0]  nbytes;
    logic [7:0]  stride;
    logic [2:0]  row_bytes;
    font_kind_t  kind;
  } font_info_t;

  localparam int FONT_COUNT = 19;
  localparam int INDEX_W = 13;
  localparam int SEL_W = 5;

  // Queue entry passed from the classifier to the address unit
  typedef struct packed {
    logic               ok;
    logic [INDEX_W-1:0] index;
    logic [SEL_W-1:0]   font;
  } glyph_job_t;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] ASCII_FIRST = 16'h0020;
  localparam logic [15:0] ASCII_LAST = 16'h007E;
  localparam logic [7:0] HZ_CELL_FIRST = 8'hA1;
  localparam logic [7:0] HZ_CELL_LAST = 8'hFE;
  localparam logic [7:0] HZ_ROW1_FIRST = 8'hA1;
  localparam logic [7:0] HZ_ROW1_LAST = 8'hA9;
  localparam logic [7:0] HZ_ROW2_FIRST = 8'hB0;
  localparam logic [7:0] HZ_ROW2_LAST = 8'hF7;
  localparam logic [INDEX_W-1:0] HZ_ROW_CELLS = 13'd94;
  localparam logic [INDEX_W-1:0] HZ_SECOND_START = 13'd846;

  localparam font_info_t FONT_NONE = '{24'h0, 6'd0, 6'd0, 8'd0, 8'd0, 3'd0, KIND_NONE};

  localparam font_info_t FONT_TAB [FONT_COUNT] = '{
    '{24'h1DDF80, 6'd5,  6'd7,  8'd8,   8'd8,   3'd1, KIND_ASCII},
    '{24'h1DE280, 6'd7,  6'd8,  8'd8,   8'd8,   3'd1, KIND_ASCII},
    '{24'h1DBE00, 6'd6,  6'd12, 8'd12,  8'd12,  3'd1, KIND_ASCII},
    '{24'h1DD780, 6'd8,  6'd16, 8'd16,  8'd16,  3'd1, KIND_ASCII},
    '{24'h1DFF00, 6'd12, 6'd24, 8'd48,  8'd48,  3'd2, KIND_ASCII},
    '{24'h1E5A50, 6'd16, 6'd32, 8'd64,  8'd64,  3'd2, KIND_ASCII},
    '{24'h1DDF80, 6'd8,  6'd16, 8'd16,  8'd8,   3'd1, KIND_ASCII},
    FONT_NONE, FONT_NONE, FONT_NONE, FONT_NONE,
    FONT_NONE, FONT_NONE, FONT_NONE, FONT_NONE,
    '{24'h000000, 6'd12, 6'd12, 8'd24,  8'd24,  3'd2, KIND_HANZI},
    '{24'h02C9D0, 6'd15, 6'd16, 8'd32,  8'd32,  3'd2, KIND_HANZI},
    '{24'h068190, 6'd24, 6'd24, 8'd72,  8'd72,  3'd3, KIND_HANZI},
    '{24'h0EDF00, 6'd32, 6'd32, 8'd128, 8'd128, 3'd4, KIND_HANZI}
  };

  function automatic font_info_t font_lookup(input logic [SEL_W-1:0] sel);
    font_info_t info;
    info = FONT_NONE;
    if (int'(sel) < FONT_COUNT) begin
      info = FONT_TAB[sel];
    end
    return info;
  endfunction

endpackage

// File: sv/frga_req_if.sv
interface frga_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic [4:0]  font_select;

  modport source (output valid, output char_code, output font_select, input ready);
  modport sink (input valid, input char_code, input font_select, output ready);
endinterface

// File: sv/frga_rsp_if.sv
interface frga_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] glyph_address;
  logic        address_valid;
  logic [5:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [7:0]  glyph_bytes;
  logic [2:0]  row_bytes;

  modport source (output valid, output glyph_address, output address_valid,
                  output glyph_width, output glyph_height, output glyph_bytes,
                  output row_bytes, input ready);
  modport sink (input valid, input glyph_address, input address_valid,
                input glyph_width, input glyph_height, input glyph_bytes,
                input row_bytes, output ready);
endinterface

// File: sv/frga_front.sv
module frga_front import frga_pkg::*; (
  frga_req_if.sink   req,
  output logic       push_valid,
  input  logic       push_ready,
  output glyph_job_t push_data
);

  font_info_t         info;
  logic [7:0]         row;
  logic [7:0]         cell_byte;
  logic               ascii_ok;
  logic               cell_ok;
  logic               row1_ok;
  logic               row2_ok;
  logic [6:0]         row_off;
  logic [6:0]         cell_off;
  logic [INDEX_W-1:0] row_base;
  logic [INDEX_W-1:0] hz_index;
  logic [INDEX_W-1:0] ascii_index;

  assign info      = font_lookup(req.font_select);
  assign row       = req.char_code[15:8];
  assign cell_byte = req.char_code[7:0];

  assign ascii_ok = (req.char_code >= ASCII_FIRST) && (req.char_code <= ASCII_LAST);
  assign cell_ok  = (cell_byte >= HZ_CELL_FIRST) && (cell_byte <= HZ_CELL_LAST);
  assign row1_ok  = (row >= HZ_ROW1_FIRST) && (row <= HZ_ROW1_LAST);
  assign row2_ok  = (row >= HZ_ROW2_FIRST) && (row <= HZ_ROW2_LAST);

  always_comb begin
    row_off  = row1_ok ? 7'(row - HZ_ROW1_FIRST) : 7'(row - HZ_ROW2_FIRST);
    cell_off = 7'(cell_byte - HZ_CELL_FIRST);
    row_base = INDEX_W'(INDEX_W'(row_off) * HZ_ROW_CELLS);
    // second block of rows continues after the symbol rows
    hz_index = row_base + INDEX_W'(cell_off) + (row2_ok ? HZ_SECOND_START : '0);
    ascii_index = INDEX_W'(req.char_code - ASCII_FIRST);
  end

  always_comb begin
    push_data.font  = req.font_select;
    push_data.ok    = 1'b0;
    push_data.index = '0;
    unique case (info.kind)
      KIND_ASCII: begin
        push_data.ok    = ascii_ok;
        push_data.index = ascii_index;
      end
      KIND_HANZI: begin
        push_data.ok    = cell_ok && (row1_ok || row2_ok);
        push_data.index = hz_index;
      end
      default: begin
        push_data.ok = 1'b0;
      end
    endcase
  end

  assign push_valid = req.valid;
  assign req.ready  = push_ready;

endmodule

// File: sv/frga_queue.sv
module frga_queue import frga_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  glyph_job_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output glyph_job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  glyph_job_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on request");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

// File: sv/frga_back.sv
module frga_back import frga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  glyph_job_t pop_data,
  frga_rsp_if.source rsp
);

  localparam int PROD_W = INDEX_W + 8;

  font_info_t        info;
  logic [PROD_W-1:0] offset;
  logic [23:0]       addr;
  logic              load;

  assign info   = font_lookup(pop_data.font);
  assign offset = PROD_W'(pop_data.index) * PROD_W'(info.stride);
  assign addr   = 24'(offset) + info.base;

  // output register frees up as soon as the receiver takes the request
  assign load      = !rsp.valid || rsp.ready;
  assign pop_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      if (pop_data.ok) begin
        rsp.glyph_address <= addr;
        rsp.address_valid <= 1'b1;
        rsp.glyph_width   <= info.width;
        rsp.glyph_height  <= info.height;
        rsp.glyph_bytes   <= info.nbytes;
        rsp.row_bytes     <= info.row_bytes;
      end else begin
        rsp.glyph_address <= '0;
        rsp.address_valid <= 1'b0;
        rsp.glyph_width   <= '0;
        rsp.glyph_height  <= '0;
        rsp.glyph_bytes   <= '0;
        rsp.row_bytes     <= '0;
      end
    end
  end

endmodule

// File: sv/font_rom_glyph_address.sv
// Glyph address lookup for a serial font ROM.
// Input channel req carries char_code (ASCII in the low byte, or a GB2312
// row/cell byte pair) and font_select. Output channel rsp carries the
// 24-bit glyph_address, address_valid and the glyph's width, height, byte
// count and bytes per row; unsupported fonts or codes return address_valid
// low with every other field zero.
// A front classifier checks the code range and forms the glyph index (one
// small multiply by the row length), pushes it into a short queue, and the
// address unit multiplies the index by the font stride, adds the font base
// and registers the result.
// A request accepted on req is written into the queue, then loaded into the
// output register once that register is free and older entries have left, and
// is offered on rsp. Throughput: one request per cycle while rsp does not stall.
// When rsp stalls, the output register holds its request and the queue
// absorbs up to QUEUE_DEPTH more; req.ready drops only when the queue is full.
// Synchronous reset empties the queue and clears rsp.valid; no clearing pass.
module font_rom_glyph_address import frga_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  frga_req_if.sink   req,
  frga_rsp_if.source rsp
);

  logic       push_valid;
  logic       push_ready;
  glyph_job_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  glyph_job_t pop_data;

  frga_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  frga_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  frga_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (rsp)
  );

endmodule
